// ===== sv/cmad_pkg.sv =====
// cmad_pkg: constants, widths and the divider request/response types
// shared by the cascaded moving-average detrend block; no dependencies
`default_nettype none

package cmad_pkg;

   // window lengths
   localparam int SMOOTH_LEN = 50;
   localparam int CENTER_LEN = 500;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int SMOOTHED_W = 24;
   localparam int CENTERED_W = 25;

   // running sums
   localparam int RAW_SUM_W = 22;
   localparam int SM_SUM_W  = 33;

   // window addressing and fill counts
   localparam int RAW_AW = (SMOOTH_LEN > 1) ? $clog2(SMOOTH_LEN) : 1;
   localparam int SM_AW  = (CENTER_LEN > 1) ? $clog2(CENTER_LEN) : 1;
   localparam int RAW_FW = $clog2(SMOOTH_LEN + 1);
   localparam int SM_FW  = $clog2(CENTER_LEN + 1);

   // shared divider: signed dividend, unsigned divisor
   localparam int DIV_W   = SM_SUM_W + 1;
   localparam int MAG_W   = DIV_W - 1;
   localparam int MAX_LEN = (SMOOTH_LEN > CENTER_LEN) ? SMOOTH_LEN : CENTER_LEN;
   localparam int DVS_W   = $clog2(MAX_LEN + 1);
   localparam int CNT_W   = $clog2(MAG_W + 1);

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic        [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== sv/cmad_ram.sv =====
// cmad_ram: generic single-write, single-read memory with registered read data
// no package dependency
`default_nettype none

module cmad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/cmad_div.sv =====
// cmad_div: iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero; depends on cmad_pkg
`default_nettype none

module cmad_div
   import cmad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DIV_W-1:0] mag_full;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;
   logic [DIV_W-1:0] quo_ext;

   // one restoring step
   always_comb begin
      mag_full = req.dividend[DIV_W-1] ? (-req.dividend) : req.dividend;
      trial    = {rem_ff, quo_ff[MAG_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      fits     = (trial >= {1'b0, dvs_ff});
   end

   // next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.dividend[DIV_W-1];
         cnt_in  = CNT_W'(MAG_W);
         quo_in  = mag_full[MAG_W-1:0];
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[MAG_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // restore the sign
   always_comb begin
      quo_ext      = {1'b0, quo_ff};
      rsp.done     = done_ff;
      rsp.quotient = neg_ff ? (-quo_ext) : quo_ext;
   end

endmodule

`default_nettype wire

// ===== sv/cascaded_moving_average_detrend_top.sv =====
// one sample at a time: req_stall is raised outside the idle state, so a new sample
// waits until the current one has made both passes through the shared divider and
// its results are loaded into the response register, which waits while rsp_stall is high
// reset: synchronous, active high; clears sums, fill counts, heads and handshake state
// window memories are not cleared; entries are read only after being written
// depends on cmad_pkg, cmad_ram, cmad_div
`default_nettype none

module cascaded_moving_average_detrend_top
   import cmad_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [SAMPLE_W-1:0]   req_sample,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed      [SMOOTHED_W-1:0] rsp_smoothed,
   output logic signed      [CENTERED_W-1:0] rsp_centered
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAW_UPD,
      ST_DIV_RAW,
      ST_SM_UPD,
      ST_DIV_SM,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic signed [RAW_SUM_W-1:0]  raw_sum_ff, raw_sum_in;
   logic        [RAW_FW-1:0]     raw_fill_ff, raw_fill_in;
   logic        [RAW_AW-1:0]     raw_head_ff, raw_head_in;
   logic signed [SM_SUM_W-1:0]   sm_sum_ff, sm_sum_in;
   logic        [SM_FW-1:0]      sm_fill_ff, sm_fill_in;
   logic        [SM_AW-1:0]      sm_head_ff, sm_head_in;
   logic signed [SMOOTHED_W-1:0] smoothed_ff, smoothed_in;
   logic signed [CENTERED_W-1:0] centered_ff, centered_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SMOOTHED_W-1:0] rsp_smoothed_ff, rsp_smoothed_in;
   logic signed [CENTERED_W-1:0] rsp_centered_ff, rsp_centered_in;

   logic                         req_take;
   logic                         raw_full;
   logic                         sm_full;
   logic signed [SAMPLE_W-1:0]   raw_old;
   logic signed [SMOOTHED_W-1:0] sm_old;
   logic        [SAMPLE_W-1:0]   raw_rd_data;
   logic        [SMOOTHED_W-1:0] sm_rd_data;
   logic                         raw_wr_en;
   logic                         sm_wr_en;
   logic                         sm_rd_en;
   logic signed [RAW_SUM_W+7:0]  raw_scaled;
   div_req_type                  div_req;
   div_rsp_type                  div_rsp;

   // short window storage
   cmad_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (SMOOTH_LEN)
   ) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_wr_en),
      .wr_addr (raw_head_ff),
      .wr_data (sample_ff),
      .rd_en   (req_take),
      .rd_addr (raw_head_ff),
      .rd_data (raw_rd_data)
   );

   // long window storage
   cmad_ram #(
      .WIDTH (SMOOTHED_W),
      .DEPTH (CENTER_LEN)
   ) u_sm_ram (
      .clock   (clock),
      .wr_en   (sm_wr_en),
      .wr_addr (sm_head_ff),
      .wr_data (smoothed_ff),
      .rd_en   (sm_rd_en),
      .rd_addr (sm_head_ff),
      .rd_data (sm_rd_data)
   );

   // shared divider
   cmad_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // handshake and window status
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      req_take  = req_valid && !req_stall;
      raw_full  = (raw_fill_ff == RAW_FW'(SMOOTH_LEN));
      sm_full   = (sm_fill_ff == SM_FW'(CENTER_LEN));
      raw_old   = raw_full ? $signed(raw_rd_data) : '0;
      sm_old    = sm_full ? $signed(sm_rd_data) : '0;
      raw_wr_en = (state_ff == ST_RAW_UPD);
      sm_wr_en  = (state_ff == ST_SM_UPD);
      sm_rd_en  = (state_ff == ST_RAW_UPD);
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      sample_in       = sample_ff;
      raw_sum_in      = raw_sum_ff;
      raw_fill_in     = raw_fill_ff;
      raw_head_in     = raw_head_ff;
      sm_sum_in       = sm_sum_ff;
      sm_fill_in      = sm_fill_ff;
      sm_head_in      = sm_head_ff;
      smoothed_in     = smoothed_ff;
      centered_in     = centered_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_smoothed_in = rsp_smoothed_ff;
      rsp_centered_in = rsp_centered_ff;
      raw_scaled      = '0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req_sample;
               state_in  = ST_RAW_UPD;
            end
         end
         ST_RAW_UPD: begin
            // drop the oldest sample once full, add the new one
            raw_sum_in = raw_sum_ff - RAW_SUM_W'(raw_old) + RAW_SUM_W'(sample_ff);
            if (!raw_full) begin
               raw_fill_in = raw_fill_ff + RAW_FW'(1);
            end
            raw_head_in = (raw_head_ff == RAW_AW'(SMOOTH_LEN - 1)) ?
                          '0 : raw_head_ff + RAW_AW'(1);
            raw_scaled       = {raw_sum_in, 8'b0};
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(raw_scaled);
            div_req.divisor  = DVS_W'(raw_fill_in);
            state_in         = ST_DIV_RAW;
         end
         ST_DIV_RAW: begin
            if (div_rsp.done) begin
               smoothed_in = div_rsp.quotient[SMOOTHED_W-1:0];
               state_in    = ST_SM_UPD;
            end
         end
         ST_SM_UPD: begin
            // same update on the long window of smoothed values
            sm_sum_in = sm_sum_ff - SM_SUM_W'(sm_old) + SM_SUM_W'(smoothed_ff);
            if (!sm_full) begin
               sm_fill_in = sm_fill_ff + SM_FW'(1);
            end
            sm_head_in = (sm_head_ff == SM_AW'(CENTER_LEN - 1)) ?
                         '0 : sm_head_ff + SM_AW'(1);
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(sm_sum_in);
            div_req.divisor  = DVS_W'(sm_fill_in);
            state_in         = ST_DIV_SM;
         end
         ST_DIV_SM: begin
            if (div_rsp.done) begin
               centered_in = CENTERED_W'(smoothed_ff) -
                             div_rsp.quotient[CENTERED_W-1:0];
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the response register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_smoothed_in = smoothed_ff;
               rsp_centered_in = centered_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         raw_sum_ff   <= '0;
         raw_fill_ff  <= '0;
         raw_head_ff  <= '0;
         sm_sum_ff    <= '0;
         sm_fill_ff   <= '0;
         sm_head_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         raw_sum_ff   <= raw_sum_in;
         raw_fill_ff  <= raw_fill_in;
         raw_head_ff  <= raw_head_in;
         sm_sum_ff    <= sm_sum_in;
         sm_fill_ff   <= sm_fill_in;
         sm_head_ff   <= sm_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff       <= sample_in;
      smoothed_ff     <= smoothed_in;
      centered_ff     <= centered_in;
      rsp_smoothed_ff <= rsp_smoothed_in;
      rsp_centered_ff <= rsp_centered_in;
   end

   // response ports
   always_comb begin
      rsp_valid    = rsp_valid_ff;
      rsp_smoothed = rsp_smoothed_ff;
      rsp_centered = rsp_centered_ff;
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for cascaded_moving_average_detrend_top: a queue-fed driver, a
// monitor and a running-sum predictor of the smoothed and centered outputs
// depends on cmad_pkg and the detrend top level with its ram and divider
`timescale 1ns / 1ps

module testbench
   import cmad_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS  = 95;

   // shapes of random sample runs
   typedef enum int {
      SEG_NOISE,
      SEG_RAIL,
      SEG_JITTER,
      SEG_RAMP,
      SEG_TOGGLE
   } seg_kind_type;

   typedef struct packed {
      logic signed [SMOOTHED_W-1:0] smoothed;
      logic signed [CENTERED_W-1:0] centered;
   } detrend_out_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [SAMPLE_W-1:0]   req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [SMOOTHED_W-1:0] rsp_smoothed;
   logic signed [CENTERED_W-1:0] rsp_centered;

   logic signed [SAMPLE_W-1:0] pending_samples[$];
   detrend_out_type            expected_detrend[$];

   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int mismatch_count    = 0;
   int cycle_count       = 0;

   // predictor state: short window of raw samples, long window of smoothed values
   longint raw_window[SMOOTH_LEN];
   longint raw_total   = 0;
   int     raw_count   = 0;
   int     raw_slot    = 0;
   longint smooth_window[CENTER_LEN];
   longint smooth_total = 0;
   int     smooth_count = 0;
   int     smooth_slot  = 0;

   cascaded_moving_average_detrend_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_smoothed (rsp_smoothed),
      .rsp_centered (rsp_centered)
   );

   always #5 clock = ~clock;

   // push one sample through both windows and queue the expected transaction
   function automatic void predict_detrend(input logic signed [SAMPLE_W-1:0] sample);
      longint          smoothed;
      longint          baseline;
      longint          centered;
      detrend_out_type result;
      if (raw_count >= SMOOTH_LEN) begin
         raw_total -= raw_window[raw_slot];
      end else begin
         raw_count++;
      end
      raw_window[raw_slot] = longint'(sample);
      raw_total += longint'(sample);
      raw_slot = (raw_slot + 1) % SMOOTH_LEN;
      smoothed = (raw_total * 256) / longint'(raw_count);

      if (smooth_count >= CENTER_LEN) begin
         smooth_total -= smooth_window[smooth_slot];
      end else begin
         smooth_count++;
      end
      smooth_window[smooth_slot] = smoothed;
      smooth_total += smoothed;
      smooth_slot = (smooth_slot + 1) % CENTER_LEN;
      baseline = smooth_total / longint'(smooth_count);
      centered = smoothed - baseline;

      result.smoothed = smoothed[SMOOTHED_W-1:0];
      result.centered = centered[CENTERED_W-1:0];
      expected_detrend.push_back(result);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] to_sample(input int value);
      if (value > 32767) return 16'sh7fff;
      if (value < -32768) return -16'sh8000;
      return value[SAMPLE_W-1:0];
   endfunction

   // random runs that look like breathing traces, rail hits and plain noise
   task automatic queue_segments(input int count);
      int           pushed;
      int           len;
      int           level;
      int           step;
      int           jitter;
      int           value;
      int           k;
      seg_kind_type kind;
      pushed = 0;
      while (pushed < count) begin
         kind  = seg_kind_type'($urandom_range(0, 4));
         len   = (kind == SEG_RAIL) ? $urandom_range(50, 70) : $urandom_range(10, 60);
         if (len > count - pushed) len = count - pushed;
         value = $urandom_range(0, 65535);
         level = value - 32768;
         value = $urandom_range(0, 1200);
         step  = value - 600;
         if (kind == SEG_RAIL) level = $urandom_range(0, 1) ? 32767 : -32768;
         for (k = 0; k < len; k++) begin
            case (kind)
               SEG_NOISE: begin
                  value = $urandom_range(0, 65535);
                  value = value - 32768;
               end
               SEG_RAIL: value = level;
               SEG_JITTER: begin
                  jitter = $urandom_range(0, 64);
                  value  = level + jitter - 32;
               end
               SEG_RAMP: begin
                  level = level + step;
                  if (level > 32767 || level < -32768) step = -step;
                  value = level;
               end
               default: value = (k % 2) ? 32767 : -32768;
            endcase
            pending_samples.push_back(to_sample(value));
         end
         pushed += len;
      end
   endtask

   // driver: hold the payload while stalled, predict on each accepted transaction
   always @(posedge clock) begin : driver
      logic accepted;
      if (reset) begin
         req_valid  <= 1'b0;
         req_sample <= '0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) predict_detrend(req_sample);
         if (!req_valid || accepted) begin
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid  <= 1'b1;
               req_sample <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted transaction with the oldest expectation
   always @(posedge clock) begin : monitor
      detrend_out_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_detrend.size() == 0) begin
               $error("unexpected transaction: smoothed %0d centered %0d",
                      rsp_smoothed, rsp_centered);
               mismatch_count++;
            end else begin
               want = expected_detrend.pop_front();
               if (rsp_smoothed !== want.smoothed) begin
                  $error("smoothed: expected %0d, actual %0d", want.smoothed, rsp_smoothed);
                  mismatch_count++;
               end
               if (rsp_centered !== want.centered) begin
                  $error("centered: expected %0d, actual %0d", want.centered, rsp_centered);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: rails, single-bit patterns, sign flips while both windows fill
      pending_samples.push_back(16'sh7fff);
      pending_samples.push_back(-16'sh8000);
      pending_samples.push_back(16'sh0000);
      pending_samples.push_back(-16'sh0001);
      pending_samples.push_back(16'sh0001);
      pending_samples.push_back(16'sh5555);
      pending_samples.push_back(-16'sh5556);
      pending_samples.push_back(16'sh4000);
      pending_samples.push_back(-16'sh4000);
      pending_samples.push_back(16'sh0100);
      pending_samples.push_back(-16'sh00ff);
      pending_samples.push_back(16'sh7ffe);
      pending_samples.push_back(-16'sh7fff);
      pending_samples.push_back(16'sh0003);
      pending_samples.push_back(-16'sh0003);
      pending_samples.push_back(16'sh00ff);
      pending_samples.push_back(-16'sh0100);
      pending_samples.push_back(16'sh2aaa);
      pending_samples.push_back(-16'sh2aab);
      pending_samples.push_back(16'sh0002);

      // idle profiles; the sender drains completely between phases
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
            default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
         endcase
         queue_segments(PHASE_ITEMS);
         while (pending_samples.size() > 0 || req_valid || expected_detrend.size() > 0)
            @(posedge clock);
      end

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_detrend.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
